FILE: sv/sogi_single_phase_pll_defines.svh
// Assertion macros for the SOGI single-phase PLL.
`ifndef SOGI_SINGLE_PHASE_PLL_DEFINES_SVH
`define SOGI_SINGLE_PHASE_PLL_DEFINES_SVH
`ifndef SYNTH
`define SPLL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPLL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPLL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/spll_pkg.sv
// Package: shared constants, CORDIC table and helper functions for the PLL.
package spll_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 32;
    localparam int TRIG_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS     = 24;
    localparam int STEP_W           = 5;
    localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;

    localparam logic [2:0] REG_B0  = 3'd0;
    localparam logic [2:0] REG_A1  = 3'd1;
    localparam logic [2:0] REG_A2  = 3'd2;
    localparam logic [2:0] REG_QB  = 3'd3;
    localparam logic [2:0] REG_KP  = 3'd4;
    localparam logic [2:0] REG_KI  = 3'd5;
    localparam logic [2:0] REG_NOM = 3'd6;
    localparam logic [2:0] REG_TS  = 3'd7;

    function automatic logic signed [31:0] atan_turns(input logic [STEP_W-1:0] i);
        logic signed [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'sd536870912;
                5'd1: r = 32'sd316933406;
                5'd2: r = 32'sd167458907;
                5'd3: r = 32'sd85004756;
                5'd4: r = 32'sd42667331;
                5'd5: r = 32'sd21354465;
                5'd6: r = 32'sd10679838;
                5'd7: r = 32'sd5340245;
                5'd8: r = 32'sd2670163;
                5'd9: r = 32'sd1335087;
                5'd10: r = 32'sd667544;
                5'd11: r = 32'sd333772;
                5'd12: r = 32'sd166886;
                5'd13: r = 32'sd83443;
                5'd14: r = 32'sd41722;
                5'd15: r = 32'sd20861;
                5'd16: r = 32'sd10430;
                5'd17: r = 32'sd5215;
                5'd18: r = 32'sd2608;
                5'd19: r = 32'sd1304;
                5'd20: r = 32'sd652;
                5'd21: r = 32'sd326;
                5'd22: r = 32'sd163;
                5'd23: r = 32'sd81;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    // saturate a 64-bit value to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

    // round half up, shift by n (n >= 1)
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int n);
        logic signed [63:0] h;
        begin
            h = 64'sd1 <<< (n - 1);
            return (v + h) >>> n;
        end
    endfunction

    typedef enum logic [1:0] {
        MUL_ROUND_FS,
        MUL_ROUND_30,
        MUL_ROUND_TF,
        MUL_RAW
    } mul_mode_t;

    typedef struct packed {
        logic      start;
        mul_mode_t mode;
    } mul_ctl_t;
endpackage

FILE: sv/spll_mac.sv
// Shared signed multiplier with registered product, rounded or raw by mode.
module spll_mac #(
    parameter int FS = spll_pkg::SAMPLE_WIDTH_DEF - 2,
    parameter int TF = spll_pkg::TRIG_WIDTH_DEF - 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spll_pkg::mul_ctl_t  ctl,
    input  logic signed [32:0]  op_a,
    input  logic signed [32:0]  op_b,
    output logic signed [63:0]  prod,
    output logic                done
);
    logic signed [65:0] full;
    logic signed [63:0] prod_next;
    logic               done_reg;
    logic signed [63:0] prod_reg;

    assign full = op_a * op_b;

    always_comb
    begin
        unique case (ctl.mode)
            spll_pkg::MUL_ROUND_FS: prod_next = spll_pkg::rshr(full[63:0], FS);
            spll_pkg::MUL_ROUND_30: prod_next = spll_pkg::rshr(full[63:0], 30);
            spll_pkg::MUL_ROUND_TF: prod_next = spll_pkg::rshr(full[63:0], TF);
            default:                prod_next = full[63:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.start;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;
endmodule

FILE: sv/spll_cordic.sv
// Iterative CORDIC: one rotation per cycle, quadrant fold and rounding to trig width.
`include "sogi_single_phase_pll_defines.svh"
module spll_cordic #(
    parameter int TRIG_WIDTH = spll_pkg::TRIG_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  angle,
    output logic                         done,
    output logic signed [TRIG_WIDTH-1:0] sine,
    output logic signed [TRIG_WIDTH-1:0] cosine
);
    localparam int SH = 31 - TRIG_WIDTH;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [1:0]         quad_reg;
    logic [spll_pkg::STEP_W-1:0] i_reg;
    logic               busy_reg, done_reg;
    logic signed [TRIG_WIDTH-1:0] s_reg, c_reg;
    logic signed [33:0] xs, ys, at;
    logic signed [33:0] cx, sy;

    function automatic logic signed [TRIG_WIDTH-1:0] tout(input logic signed [33:0] v);
        logic signed [63:0] r;
        logic signed [63:0] hi;
        begin
            r  = spll_pkg::rshr(64'(v), SH);
            hi = (64'sd1 <<< (TRIG_WIDTH - 1)) - 64'sd1;
            if (r > hi)
                return hi[TRIG_WIDTH-1:0];
            else if (r < -hi - 64'sd1)
                return TRIG_WIDTH'(-hi - 64'sd1);
            else
                return r[TRIG_WIDTH-1:0];
        end
    endfunction

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = 34'(spll_pkg::atan_turns(i_reg));

    always_comb
    begin
        unique case (quad_reg)
            2'd0: begin cx = x_reg;  sy = y_reg;  end
            2'd1: begin cx = -y_reg; sy = x_reg;  end
            2'd2: begin cx = -x_reg; sy = -y_reg; end
            default: begin cx = y_reg; sy = -x_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (i_reg == spll_pkg::STEP_W'(spll_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= 34'(spll_pkg::CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= 34'({2'b00, angle[29:0]});
            quad_reg <= angle[31:30];
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (done_reg)
        begin
            s_reg <= tout(sy);
            c_reg <= tout(cx);
        end
    end

    assign done   = done_reg;
    assign sine   = s_reg;
    assign cosine = c_reg;

    `SPLL_ASSERT_NEXT(a_cordic_start_busy, clk, rst_n, start, busy_reg)
    `SPLL_ASSERT_IMPL(a_cordic_no_restart, clk, rst_n, busy_reg, !start)
    `SPLL_ASSERT_IMPL(a_cordic_done_idle, clk, rst_n, done_reg, !busy_reg)
endmodule

FILE: sv/sogi_single_phase_pll.sv
// SOGI single-phase PLL top level: sequencer, state and output register.
// Usage:
//   Input channel: ac_sample with in_valid / in_stall. One word is one grid
//   sample, signed Q2.(SAMPLE_WIDTH-2) per unit.
//   Output channel: sine_out, cosine_out, phase_out, freq_out, direct_out,
//   quad_out with out_valid / out_stall; exactly one word per input word.
//   Config: cfg_we, cfg_index, cfg_data; write only while idle. Unknown
//   indexes are ignored.
// Timing: one shared 33x33 multiplier does the 13 products in sequence,
//   then the CORDIC runs 24 rotations one per cycle. The next word is taken
//   once the result has left the output register, so the block does not
//   take a new word before it is through with the last one.
// Reset: all filter history, the loop integrator, phase and stored sine and
//   cosine clear to zero; registers return to their default coefficients.
// Stall: a held result stays in the output register while out_stall is high;
//   the block does not take a new word until that result has left.
`include "sogi_single_phase_pll_defines.svh"
module sogi_single_phase_pll #(
    parameter int SAMPLE_WIDTH = spll_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = spll_pkg::ACC_WIDTH_DEF,
    parameter int TRIG_WIDTH   = spll_pkg::TRIG_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] ac_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [TRIG_WIDTH-1:0]   sine_out,
    output logic signed [TRIG_WIDTH-1:0]   cosine_out,
    output logic [31:0]                    phase_out,
    output logic signed [31:0]             freq_out,
    output logic signed [31:0]             direct_out,
    output logic signed [31:0]             quad_out,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [31:0]                    cfg_data
);
    localparam int FS = SAMPLE_WIDTH - 2;
    localparam int TF = TRIG_WIDTH - 1;
    localparam int PSH = 48 - ACC_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_WAIT, S_FREQ, S_INC, S_INCW, S_PHASE, S_TRIG, S_OUT
    } state_t;

    // coefficient registers
    logic signed [31:0] b0_reg, a1_reg, a2_reg, qb_reg, kp_reg, ki_reg;
    logic [30:0]        nom_reg;
    logic [31:0]        ts_reg;

    // filter state
    logic signed [SAMPLE_WIDTH-1:0] u0_reg, u1_reg, u2_reg;
    logic signed [31:0] v1_reg, v2_reg, qv1_reg, qv2_reg, pq_reg, li_reg;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic signed [TRIG_WIDTH-1:0] ls_reg, lc_reg;

    // working
    state_t             state_reg;
    logic [3:0]         k_reg;
    logic signed [63:0] sum_reg;
    logic signed [31:0] v_reg, qv_reg, q_reg, d_reg, fo_reg;
    logic               ov_reg;
    logic signed [TRIG_WIDTH-1:0] so_reg, co_reg;
    logic [31:0]        po_reg;
    logic signed [31:0] fout_reg, dout_reg, qout_reg;

    spll_pkg::mul_ctl_t mctl;
    logic signed [32:0] ma, mb;
    logic signed [63:0] prod;
    logic               mdone;
    logic               cstart, cdone;
    logic signed [TRIG_WIDTH-1:0] csin, ccos;
    logic [31:0]        p32;
    logic signed [63:0] sum_next;
    logic               accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;

    // p32 from accumulator
    always_comb
    begin
        if (ACC_WIDTH >= 32)
            p32 = 32'(acc_reg >> (ACC_WIDTH - 32));
        else
            p32 = 32'(acc_reg) << (32 - ACC_WIDTH);
    end

    // operand selection for the product sequence
    always_comb
    begin
        ma = '0;
        mb = '0;
        mctl.mode = spll_pkg::MUL_ROUND_30;
        unique case (k_reg)
            4'd0: begin ma = 33'(b0_reg); mb = 33'(u0_reg) - 33'(u2_reg);
                mctl.mode = spll_pkg::MUL_ROUND_FS; end
            4'd1: begin ma = 33'(a1_reg); mb = 33'(v1_reg); end
            4'd2: begin ma = 33'(a2_reg); mb = 33'(v2_reg); end
            4'd3: begin ma = 33'(qb_reg);
                mb = 33'(u0_reg) + (33'(u1_reg) <<< 1) + 33'(u2_reg);
                mctl.mode = spll_pkg::MUL_ROUND_FS; end
            4'd4: begin ma = 33'(a1_reg); mb = 33'(qv1_reg); end
            4'd5: begin ma = 33'(a2_reg); mb = 33'(qv2_reg); end
            4'd6: begin ma = 33'(lc_reg); mb = 33'(v_reg); mctl.mode = spll_pkg::MUL_RAW; end
            4'd7: begin ma = 33'(ls_reg); mb = 33'(qv_reg); mctl.mode = spll_pkg::MUL_RAW; end
            4'd8: begin ma = 33'(lc_reg); mb = 33'(qv_reg); mctl.mode = spll_pkg::MUL_RAW; end
            4'd9: begin ma = 33'(ls_reg); mb = -33'(v_reg); mctl.mode = spll_pkg::MUL_RAW; end
            4'd10: begin ma = 33'(kp_reg); mb = 33'(q_reg); end
            4'd11: begin ma = 33'(ki_reg); mb = 33'(pq_reg); end
            4'd12: begin ma = 33'(fo_reg); mb = 33'({1'b0, ts_reg}); mctl.mode = spll_pkg::MUL_RAW; end
            default: begin ma = '0; mb = '0; end
        endcase
        mctl.start = (state_reg == S_MUL) || (state_reg == S_INC);
    end

    spll_mac #(.FS(FS), .TF(TF)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(mctl), .op_a(ma), .op_b(mb),
        .prod(prod), .done(mdone)
    );

    assign cstart = (state_reg == S_PHASE);

    spll_cordic #(.TRIG_WIDTH(TRIG_WIDTH)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .angle(p32),
        .done(cdone), .sine(csin), .cosine(ccos)
    );

    assign sum_next = sum_reg + prod;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg  <= 32'sd4199800;
            a1_reg  <= 32'sd2138819600;
            a2_reg  <= -32'sd1065341900;
            qb_reg  <= 32'sd32985;
            kp_reg  <= 32'sd10936480;
            ki_reg  <= -32'sd10900100;
            nom_reg <= 31'd3276800;
            ts_reg  <= 32'd214748;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spll_pkg::REG_B0:  b0_reg  <= cfg_data;
                spll_pkg::REG_A1:  a1_reg  <= cfg_data;
                spll_pkg::REG_A2:  a2_reg  <= cfg_data;
                spll_pkg::REG_QB:  qb_reg  <= cfg_data;
                spll_pkg::REG_KP:  kp_reg  <= cfg_data;
                spll_pkg::REG_KI:  ki_reg  <= cfg_data;
                spll_pkg::REG_NOM: nom_reg <= cfg_data[30:0];
                default:           ts_reg  <= cfg_data;
            endcase
        end
    end

    // sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            u0_reg <= '0; u1_reg <= '0; u2_reg <= '0;
            v1_reg <= '0; v2_reg <= '0; qv1_reg <= '0; qv2_reg <= '0;
            pq_reg <= '0; li_reg <= '0; acc_reg <= '0;
            ls_reg <= '0; lc_reg <= '0;
            sum_reg <= '0;
            v_reg <= '0; qv_reg <= '0; q_reg <= '0; d_reg <= '0; fo_reg <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall && state_reg != S_OUT)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        u2_reg    <= u1_reg;
                        u1_reg    <= u0_reg;
                        u0_reg    <= ac_sample;
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    k_reg <= k_reg + 1'b1;
                    unique case (k_reg)
                        4'd2:
                        begin
                            v_reg     <= spll_pkg::sat32(sum_next);
                            sum_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                        4'd5:
                        begin
                            qv_reg    <= spll_pkg::sat32(sum_next);
                            sum_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                        4'd7:
                        begin
                            q_reg     <= spll_pkg::sat32(spll_pkg::rshr(sum_next, TF));
                            sum_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                        4'd9:
                        begin
                            d_reg     <= spll_pkg::sat32(spll_pkg::rshr(sum_next, TF));
                            sum_reg   <= 64'(li_reg);
                            state_reg <= S_MUL;
                        end
                        4'd11:
                        begin
                            li_reg    <= spll_pkg::sat32(sum_next);
                            state_reg <= S_FREQ;
                        end
                        default:
                        begin
                            sum_reg   <= sum_next;
                            state_reg <= S_MUL;
                        end
                    endcase
                end
                S_FREQ:
                begin
                    fo_reg    <= spll_pkg::sat32(64'(nom_reg) + 64'(li_reg));
                    v2_reg    <= v1_reg;  v1_reg  <= v_reg;
                    qv2_reg   <= qv1_reg; qv1_reg <= qv_reg;
                    pq_reg    <= q_reg;
                    state_reg <= S_INC;
                end
                S_INC:
                    state_reg <= S_INCW;
                S_INCW:
                begin
                    acc_reg   <= acc_reg + ACC_WIDTH'(spll_pkg::rshr(prod, PSH));
                    state_reg <= S_PHASE;
                end
                S_PHASE:
                    state_reg <= S_TRIG;
                S_TRIG:
                begin
                    if (cdone)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ls_reg    <= csin;
                        lc_reg    <= ccos;
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            so_reg   <= csin;
            co_reg   <= ccos;
            po_reg   <= p32;
            fout_reg <= fo_reg;
            dout_reg <= d_reg;
            qout_reg <= q_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign sine_out   = so_reg;
    assign cosine_out = co_reg;
    assign phase_out  = po_reg;
    assign freq_out   = fout_reg;
    assign direct_out = dout_reg;
    assign quad_out   = qout_reg;

    `SPLL_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `SPLL_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == S_MUL)
    `SPLL_ASSERT_IMPL(a_mul_idle_trig, clk, rst_n, state_reg == S_TRIG, !mctl.start)
    `SPLL_ASSERT_IMPL(a_mac_product_ready, clk, rst_n, (state_reg == S_WAIT) || (state_reg == S_INCW), mdone)
endmodule

FILE: tb/tb_sogi_single_phase_pll.sv
// Testbench for the SOGI single-phase PLL: bit-exact predictor and scoreboard.
`timescale 1ns / 100ps
module tb_sogi_single_phase_pll;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    // Per-word result as the block reports it.
    typedef struct packed {
        logic signed [15:0] sine;
        logic signed [15:0] cosine;
        logic [31:0]        phase;
        logic signed [31:0] freq;
        logic signed [31:0] direct;
        logic signed [31:0] quad;
    } pll_word_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic signed [15:0]  ac_sample;
    logic                out_valid;
    logic                out_stall;
    logic signed [15:0]  sine_out;
    logic signed [15:0]  cosine_out;
    logic [31:0]         phase_out;
    logic signed [31:0]  freq_out;
    logic signed [31:0]  direct_out;
    logic signed [31:0]  quad_out;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    sogi_single_phase_pll u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ac_sample  (ac_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sine_out   (sine_out),
        .cosine_out (cosine_out),
        .phase_out  (phase_out),
        .freq_out   (freq_out),
        .direct_out (direct_out),
        .quad_out   (quad_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor copy of the coefficients.
    longint coef_b0, coef_a1, coef_a2, coef_qb, gain_now, gain_prev, nom_freq;
    longint period_ts;
    // Predictor copy of the filter and loop state.
    longint hist_u[2];
    longint hist_v[2];
    longint hist_qv[2];
    longint prev_q;
    longint integ;
    logic [31:0] phase_acc;
    longint held_sin;
    longint held_cos;

    pll_word_t expected_words[$];

    // Idling controls; percentages of cycles.
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_stall;
    int  errors;
    int  mismatches;
    int  idle_cycles;
    bit  timed_out;

    function automatic longint round_sh(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat_w(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24];
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    // Quadrant split then 24 rotations; rounds to Q1.15 and saturates.
    task automatic sin_cos_of(input logic [31:0] ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint cx;
        longint sy;
        x = 652032874;
        y = 0;
        z = ang[29:0];
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        case (ang[31:30])
            2'd0: begin cx = x;  sy = y;  end
            2'd1: begin cx = -y; sy = x;  end
            2'd2: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        c = sat_w(round_sh(cx, 15), 16);
        s = sat_w(round_sh(sy, 15), 16);
    endtask

    task automatic predict_pll_step(input logic signed [15:0] smp);
        longint u0;
        longint ip;
        longint qp;
        longint q;
        longint d;
        longint fo;
        longint inc;
        longint s;
        longint c;
        pll_word_t w;
        u0 = smp;
        ip = sat_w(round_sh(coef_b0 * (u0 - hist_u[1]), 14)
                   + round_sh(coef_a1 * hist_v[0], 30)
                   + round_sh(coef_a2 * hist_v[1], 30), 32);
        qp = sat_w(round_sh(coef_qb * (u0 + 2 * hist_u[0] + hist_u[1]), 14)
                   + round_sh(coef_a1 * hist_qv[0], 30)
                   + round_sh(coef_a2 * hist_qv[1], 30), 32);
        hist_v[1] = hist_v[0];   hist_v[0] = ip;
        hist_qv[1] = hist_qv[0]; hist_qv[0] = qp;
        hist_u[1] = hist_u[0];   hist_u[0] = u0;
        q = sat_w(round_sh(held_cos * ip + held_sin * qp, 15), 32);
        d = sat_w(round_sh(held_cos * qp - held_sin * ip, 15), 32);
        integ = sat_w(integ + round_sh(gain_now * q, 30) + round_sh(gain_prev * prev_q, 30), 32);
        prev_q = q;
        fo = sat_w(nom_freq + integ, 32);
        inc = round_sh(fo * period_ts, 16);
        phase_acc = phase_acc + inc[31:0];
        sin_cos_of(phase_acc, s, c);
        held_sin = s;
        held_cos = c;
        w.sine = s[15:0];
        w.cosine = c[15:0];
        w.phase = phase_acc;
        w.freq = fo[31:0];
        w.direct = d[31:0];
        w.quad = q[31:0];
        expected_words.push_back(w);
    endtask

    task automatic predictor_reset();
        coef_b0 = 4199800; coef_a1 = 2138819600; coef_a2 = -1065341900;
        coef_qb = 32985; gain_now = 10936480; gain_prev = -10900100;
        nom_freq = 3276800; period_ts = 214748;
        hist_u = '{0, 0}; hist_v = '{0, 0}; hist_qv = '{0, 0};
        prev_q = 0; integ = 0; phase_acc = '0; held_sin = 0; held_cos = 0;
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            spll_pkg::REG_B0:  coef_b0 = longint'(signed'(val));
            spll_pkg::REG_A1:  coef_a1 = longint'(signed'(val));
            spll_pkg::REG_A2:  coef_a2 = longint'(signed'(val));
            spll_pkg::REG_QB:  coef_qb = longint'(signed'(val));
            spll_pkg::REG_KP:  gain_now = longint'(signed'(val));
            spll_pkg::REG_KI:  gain_prev = longint'(signed'(val));
            spll_pkg::REG_NOM: nom_freq = longint'(val[30:0]);
            default: period_ts = longint'(val);
        endcase
    endtask

    // One word on the input channel; idle gaps ahead of it at the set rate.
    // Valid stays high after acceptance until the next gap or the drain.
    task automatic send_sample(input logic signed [15:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ac_sample <= smp;
        predict_pll_step(smp);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random sample: mostly a sine-like wave with noise, sometimes a raw random word.
    function automatic logic signed [15:0] wave_sample(int n, int amp, int per);
        real ph;
        ph = 2.0 * 3.14159265 * n / per;
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'(int'(amp * $sin(ph)) + $urandom_range(200) - 100);
    endfunction

    task automatic test_directed_extremes();
        logic signed [15:0] vals[10];
        vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh0001};
        foreach (vals[i])
            send_sample(vals[i]);
        for (int i = 0; i < 12; i++)
            send_sample(wave_sample(i, 16384, 12));
        wait_drained();
    endtask

    // Random run under the current coefficients and idling mix.
    task automatic test_random_wave(input int count, input int amp, input int per);
        for (int i = 0; i < count; i++)
            send_sample(wave_sample(i, amp, per));
        wait_drained();
    endtask

    // Zero and full-scale nominal frequency, zero period, saturating gains, random registers, then defaults back.
    task automatic test_register_extremes();
        write_reg(spll_pkg::REG_NOM, 32'h0000_0000);
        write_reg(spll_pkg::REG_KP, 32'h8000_0000);
        write_reg(spll_pkg::REG_KI, 32'h7fff_ffff);
        test_random_wave(60, 32767, 7);
        write_reg(spll_pkg::REG_TS, 32'h0000_0000);
        test_random_wave(20, 8000, 9);
        write_reg(spll_pkg::REG_TS, 32'hffff_ffff);
        write_reg(spll_pkg::REG_NOM, 32'h7fff_ffff);
        write_reg(spll_pkg::REG_B0, 32'h7fff_ffff);
        write_reg(spll_pkg::REG_A1, 32'h8000_0000);
        write_reg(spll_pkg::REG_A2, 32'h7fff_ffff);
        write_reg(spll_pkg::REG_QB, 32'h8000_0000);
        test_random_wave(60, 32767, 5);
        write_reg(spll_pkg::REG_TS, 32'h0000_0001);
        write_reg(spll_pkg::REG_NOM, 32'hffff_ffff);
        write_reg(spll_pkg::REG_B0, 32'h8000_0000);
        write_reg(spll_pkg::REG_QB, 32'h7fff_ffff);
        test_random_wave(40, 20000, 11);
        for (int r = 0; r < 8; r++)
            write_reg(r[2:0], $urandom);
        test_random_wave(60, 16384, 13);
        write_reg(spll_pkg::REG_B0, 32'd4199800);
        write_reg(spll_pkg::REG_A1, 32'd2138819600);
        write_reg(spll_pkg::REG_A2, -32'sd1065341900);
        write_reg(spll_pkg::REG_QB, 32'd32985);
        write_reg(spll_pkg::REG_KP, 32'd10936480);
        write_reg(spll_pkg::REG_KI, -32'sd10900100);
        write_reg(spll_pkg::REG_NOM, 32'd3276800);
        write_reg(spll_pkg::REG_TS, 32'd214748);
    endtask

    // Receiver holds off long enough for the input to back up.
    task automatic test_backpressure();
        hold_stall = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_stall = 1'b0;
            end
            test_random_wave(20, 16000, 20);
        join
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  stall_pct = 0;  test_random_wave(330, 16384, 333);
        send_idle_pct = 59; stall_pct = 0;  test_random_wave(330, 16384, 200);
        send_idle_pct = 0;  stall_pct = 59; test_random_wave(330, 12000, 250);
        send_idle_pct = 32; stall_pct = 32; test_random_wave(330, 16384, 333);
    endtask

    // Receiver stall: random, or held by the backpressure test.
    always @(posedge clk)
    begin
        out_stall <= hold_stall || ($urandom_range(99) < stall_pct);
    end

    // Scoreboard: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        pll_word_t exp_w;
        pll_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {sine_out, cosine_out, phase_out, freq_out, direct_out, quad_out};
            if (expected_words.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp sin %0d cos %0d ph %h f %0d d %0d q %0d / got sin %0d cos %0d ph %h f %0d d %0d q %0d",
                                 exp_w.sine, exp_w.cosine, exp_w.phase, exp_w.freq,
                                 exp_w.direct, exp_w.quad, got.sine, got.cosine,
                                 got.phase, got.freq, got.direct, got.quad);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb_sogi_single_phase_pll: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        ac_sample = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        predictor_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_register_extremes();
        test_backpressure();
        test_idle_phases();
        wait_drained();
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_sogi_single_phase_pll: done, clean");
        else
            $display("tb_sogi_single_phase_pll: done, errors");
        $finish;
    end
endmodule
